// ===== hw/rtl/double_ended_queue_core_defines.svh =====
// assertion macros shared by the queue core
`ifndef DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DQ_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("queue core check failed");

// next-cycle implication, checked outside reset
`define DQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("queue core check failed");

`endif

// ===== hw/rtl/dq_pkg.sv =====
package dq_pkg;

   localparam int DEPTH     = 32;
   localparam int DATA_W    = 32;
   localparam int ACTION_W  = 3;
   localparam int POS_W     = 5;
   localparam int STATUS_W  = 2;
   localparam int FILL_W    = 6;
   localparam int PTR_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int SUM_W     = ((PTR_W > POS_W) ? PTR_W : POS_W) + 1;

   // result queue between the memory stage and the output channel
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_PEEK       = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic              wr_en;
      logic [PTR_W-1:0]  wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [PTR_W-1:0]  rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic              valid;
      logic              use_ram;
      logic [DATA_W-1:0] data;
      status_type        status;
      logic [FILL_W-1:0] fill;
   } stage_type;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      status_type        status;
      logic [FILL_W-1:0] fill;
   } result_type;

endpackage

// ===== hw/rtl/dq_if.sv =====
interface dq_req_if;
   logic                         valid;
   logic                         ready;
   logic [dq_pkg::ACTION_W-1:0]  action;
   logic [dq_pkg::DATA_W-1:0]    push_data;
   logic [dq_pkg::POS_W-1:0]     peek_position;

   modport source (output valid, action, push_data, peek_position, input ready);
   modport sink (input valid, action, push_data, peek_position, output ready);
endinterface

interface dq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [dq_pkg::DATA_W-1:0]    read_data;
   logic [dq_pkg::STATUS_W-1:0]  status;
   logic [dq_pkg::FILL_W-1:0]    fill_count;

   modport source (output valid, read_data, status, fill_count, input ready);
   modport sink (input valid, read_data, status, fill_count, output ready);
endinterface

// ===== hw/rtl/dq_ram.sv =====
module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/dq_ctrl.sv =====
module dq_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   dq_req_if.sink                         req_if,
   input  logic [dq_pkg::RSP_CNT_W-1:0]   rsp_level,
   output dq_pkg::ram_req_type            ram_req,
   output dq_pkg::stage_type              stage
);

   logic [dq_pkg::PTR_W-1:0] front_ff, front_in;
   logic [dq_pkg::PTR_W-1:0] back_ff, back_in;
   logic [dq_pkg::CNT_W-1:0] count_ff, count_in;
   dq_pkg::stage_type        stage_ff, stage_in;

   logic                     fire;
   logic                     full;
   logic                     empty;
   logic                     peek_ok;
   logic [dq_pkg::PTR_W-1:0] front_up, front_dn, back_up, back_dn;
   logic [dq_pkg::SUM_W-1:0] peek_sum;
   logic [dq_pkg::PTR_W-1:0] peek_addr;
   logic [dq_pkg::RSP_CNT_W:0] credit_used;

   // results in flight plus those queued must leave room for this item
   assign credit_used  = {1'b0, rsp_level} + {{dq_pkg::RSP_CNT_W{1'b0}}, stage_ff.valid};
   assign req_if.ready = credit_used < (dq_pkg::RSP_CNT_W + 1)'(dq_pkg::RSP_DEPTH);
   assign fire         = req_if.valid && req_if.ready;

   assign full  = count_ff == dq_pkg::CNT_W'(dq_pkg::DEPTH);
   assign empty = count_ff == '0;

   assign front_up = (front_ff == dq_pkg::PTR_W'(dq_pkg::DEPTH - 1)) ? '0 : front_ff + 1'b1;
   assign front_dn = (front_ff == '0) ? dq_pkg::PTR_W'(dq_pkg::DEPTH - 1) : front_ff - 1'b1;
   assign back_up  = (back_ff == dq_pkg::PTR_W'(dq_pkg::DEPTH - 1)) ? '0 : back_ff + 1'b1;
   assign back_dn  = (back_ff == '0) ? dq_pkg::PTR_W'(dq_pkg::DEPTH - 1) : back_ff - 1'b1;

   // front pointer and position are each below the depth, so the sum stays under twice the depth
   assign peek_sum  = dq_pkg::SUM_W'(front_ff) + dq_pkg::SUM_W'(req_if.peek_position);
   assign peek_addr = (peek_sum >= dq_pkg::SUM_W'(dq_pkg::DEPTH))
                    ? dq_pkg::PTR_W'(peek_sum - dq_pkg::SUM_W'(dq_pkg::DEPTH))
                    : dq_pkg::PTR_W'(peek_sum);
   assign peek_ok   = dq_pkg::SUM_W'(req_if.peek_position) < dq_pkg::SUM_W'(count_ff);

   always_comb begin
      front_in         = front_ff;
      back_in          = back_ff;
      count_in         = count_ff;
      ram_req.wr_en    = 1'b0;
      ram_req.wr_addr  = back_ff;
      ram_req.wr_data  = req_if.push_data;
      ram_req.rd_en    = 1'b0;
      ram_req.rd_addr  = front_ff;
      stage_in.valid   = fire;
      stage_in.use_ram = 1'b0;
      stage_in.data    = '0;
      stage_in.status  = dq_pkg::ST_OK;

      unique case (dq_pkg::action_type'(req_if.action)) inside
         dq_pkg::ACT_PUSH_FRONT, dq_pkg::ACT_PUSH_BACK: begin
            if (full) begin
               stage_in.status = dq_pkg::ST_FULL;
            end else begin
               ram_req.wr_en = fire;
               stage_in.data = req_if.push_data;
               if (fire) begin
                  count_in = count_ff + 1'b1;
               end
               if (dq_pkg::action_type'(req_if.action) == dq_pkg::ACT_PUSH_FRONT) begin
                  ram_req.wr_addr = front_dn;
                  if (fire) begin
                     front_in = front_dn;
                  end
               end else begin
                  ram_req.wr_addr = back_ff;
                  if (fire) begin
                     back_in = back_up;
                  end
               end
            end
         end
         dq_pkg::ACT_POP_FRONT: begin
            if (empty) begin
               stage_in.status = dq_pkg::ST_EMPTY;
            end else begin
               ram_req.rd_en    = fire;
               ram_req.rd_addr  = front_ff;
               stage_in.use_ram = 1'b1;
               if (fire) begin
                  front_in = front_up;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         dq_pkg::ACT_POP_BACK: begin
            if (empty) begin
               stage_in.status = dq_pkg::ST_EMPTY;
            end else begin
               ram_req.rd_en    = fire;
               ram_req.rd_addr  = back_dn;
               stage_in.use_ram = 1'b1;
               if (fire) begin
                  back_in  = back_dn;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         dq_pkg::ACT_PEEK: begin
            if (!peek_ok) begin
               stage_in.status = dq_pkg::ST_EMPTY;
            end else begin
               ram_req.rd_en    = fire;
               ram_req.rd_addr  = peek_addr;
               stage_in.use_ram = 1'b1;
            end
         end
         default: begin
            stage_in.status = dq_pkg::ST_EMPTY;
         end
      endcase

      stage_in.fill = dq_pkg::FILL_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff       <= '0;
         back_ff        <= '0;
         count_ff       <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
         stage_ff <= stage_in;
      end
   end

   assign stage = stage_ff;

endmodule

// ===== hw/rtl/dq_rsp_buf.sv =====
module dq_rsp_buf (
   input  logic                          clock,
   input  logic                          reset,
   input  dq_pkg::stage_type             stage,
   input  logic [dq_pkg::DATA_W-1:0]     ram_rd_data,
   dq_rsp_if.source                      rsp_if,
   output logic [dq_pkg::RSP_CNT_W-1:0]  level
);

   dq_pkg::result_type            q_ff [dq_pkg::RSP_DEPTH];
   logic [dq_pkg::RSP_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [dq_pkg::RSP_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [dq_pkg::RSP_CNT_W-1:0]  level_ff, level_in;
   dq_pkg::result_type            entry;
   logic                          push;
   logic                          pop;

   // memory data lands in the cycle after the access, alongside the stage register
   always_comb begin
      entry.data   = stage.use_ram ? ram_rd_data : stage.data;
      entry.status = stage.status;
      entry.fill   = stage.fill;
   end

   assign push = stage.valid;
   assign pop  = rsp_if.valid && rsp_if.ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

   assign rsp_if.valid      = level_ff != '0;
   assign rsp_if.read_data  = q_ff[rd_ptr_ff].data;
   assign rsp_if.status     = q_ff[rd_ptr_ff].status;
   assign rsp_if.fill_count = q_ff[rd_ptr_ff].fill;
   assign level             = level_ff;

endmodule

// ===== hw/rtl/double_ended_queue_core.sv =====
// a result passes through the stage register and then the result queue before it is offered
// throughput: one item per cycle while the result queue has room, set by the single memory access each item makes
// a four-entry result queue absorbs output stalls; input stalls once it is committed
// reset: synchronous, clears front/back pointers, fill count and the result queue
// the entry memory is not cleared; entries are only read once written
`include "double_ended_queue_core_defines.svh"

module double_ended_queue_core (
   input  logic      clock,
   input  logic      reset,
   dq_req_if.sink    req_if,
   dq_rsp_if.source  rsp_if
);

   dq_pkg::ram_req_type            ram_req;
   dq_pkg::stage_type              stage;
   logic [dq_pkg::DATA_W-1:0]      ram_rd_data;
   logic [dq_pkg::RSP_CNT_W-1:0]   rsp_level;

   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_level (rsp_level),
      .ram_req   (ram_req),
      .stage     (stage)
   );

   dq_ram #(
      .WIDTH (dq_pkg::DATA_W),
      .DEPTH (dq_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   dq_rsp_buf u_rsp_buf (
      .clock       (clock),
      .reset       (reset),
      .stage       (stage),
      .ram_rd_data (ram_rd_data),
      .rsp_if      (rsp_if),
      .level       (rsp_level)
   );

   `DQ_ASSERT_IMPL(a_rsp_no_overflow, clock, reset, 1'b1, rsp_level <= dq_pkg::RSP_CNT_W'(dq_pkg::RSP_DEPTH))
   `DQ_ASSERT_NEXT(a_accept_to_stage, clock, reset, req_if.valid && req_if.ready, stage.valid)
   `DQ_ASSERT_IMPL(a_error_zero_data, clock, reset, rsp_if.valid && rsp_if.status != dq_pkg::ST_OK, rsp_if.read_data == '0)
   `DQ_ASSERT_IMPL(a_fill_bound, clock, reset, rsp_if.valid, rsp_if.fill_count <= dq_pkg::FILL_W'(dq_pkg::DEPTH))

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   import dq_pkg::*;

   // action codes the block does not define; they must leave the queue alone
   localparam logic [ACTION_W-1:0] ACT_RSVD_5 = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_RSVD_6 = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_RSVD_7 = 3'd7;

   localparam int RANDOM_ITEMS    = 320;
   localparam int SEGMENT_ITEMS   = 40;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int HOLD_OFF_AFTER  = 60;
   localparam int DRAIN_CYCLES    = 8;
   localparam int STALL_LIMIT     = 1000;
   localparam int NUM_ROWS        = 24;

   typedef struct packed {
      logic [ACTION_W-1:0] act;
      logic [DATA_W-1:0]   word;
      logic [POS_W-1:0]    pos;
      logic [5:0]          reps;
      logic                typed;
      logic [DATA_W-1:0]   exp_data;
      status_type          exp_status;
      logic [FILL_W-1:0]   exp_fill;
   } stim_row_type;

   // rows marked typed carry their result; the rest go through the queue predictor
   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{ACT_POP_FRONT,  32'h0000_0000, 5'd0,  6'd1,  1'b1, 32'h0000_0000, ST_EMPTY, 6'd0},
      '{ACT_POP_BACK,   32'h0000_0000, 5'd0,  6'd1,  1'b1, 32'h0000_0000, ST_EMPTY, 6'd0},
      '{ACT_PEEK,       32'h0000_0000, 5'd0,  6'd1,  1'b1, 32'h0000_0000, ST_EMPTY, 6'd0},
      '{ACT_RSVD_5,     32'hFFFF_FFFF, 5'd31, 6'd1,  1'b1, 32'h0000_0000, ST_EMPTY, 6'd0},
      '{ACT_RSVD_6,     32'hFFFF_FFFF, 5'd0,  6'd1,  1'b1, 32'h0000_0000, ST_EMPTY, 6'd0},
      '{ACT_RSVD_7,     32'hFFFF_FFFF, 5'd31, 6'd1,  1'b1, 32'h0000_0000, ST_EMPTY, 6'd0},
      '{ACT_PUSH_FRONT, 32'hFFFF_FFFF, 5'd0,  6'd1,  1'b1, 32'hFFFF_FFFF, ST_OK,    6'd1},
      '{ACT_PUSH_BACK,  32'h0000_0000, 5'd0,  6'd1,  1'b1, 32'h0000_0000, ST_OK,    6'd2},
      '{ACT_PEEK,       32'h0000_0000, 5'd0,  6'd1,  1'b1, 32'hFFFF_FFFF, ST_OK,    6'd2},
      '{ACT_PEEK,       32'h0000_0000, 5'd1,  6'd1,  1'b1, 32'h0000_0000, ST_OK,    6'd2},
      '{ACT_PEEK,       32'h0000_0000, 5'd2,  6'd1,  1'b1, 32'h0000_0000, ST_EMPTY, 6'd2},
      '{ACT_PEEK,       32'h0000_0000, 5'd31, 6'd1,  1'b1, 32'h0000_0000, ST_EMPTY, 6'd2},
      '{ACT_PUSH_BACK,  32'h1234_5678, 5'd0,  6'd15, 1'b0, 32'h0000_0000, ST_OK,    6'd0},
      '{ACT_PUSH_FRONT, 32'hA5A5_0000, 5'd0,  6'd15, 1'b0, 32'h0000_0000, ST_OK,    6'd0},
      '{ACT_PUSH_BACK,  32'hDEAD_BEEF, 5'd0,  6'd1,  1'b1, 32'h0000_0000, ST_FULL,  6'd32},
      '{ACT_PUSH_FRONT, 32'hDEAD_BEEF, 5'd0,  6'd1,  1'b1, 32'h0000_0000, ST_FULL,  6'd32},
      '{ACT_PEEK,       32'h0000_0000, 5'd31, 6'd1,  1'b0, 32'h0000_0000, ST_OK,    6'd0},
      '{ACT_PEEK,       32'h0000_0000, 5'd0,  6'd1,  1'b0, 32'h0000_0000, ST_OK,    6'd0},
      '{ACT_RSVD_5,     32'h0000_0000, 5'd0,  6'd1,  1'b1, 32'h0000_0000, ST_EMPTY, 6'd32},
      '{ACT_POP_BACK,   32'h0000_0000, 5'd0,  6'd16, 1'b0, 32'h0000_0000, ST_OK,    6'd0},
      '{ACT_POP_FRONT,  32'h0000_0000, 5'd0,  6'd16, 1'b0, 32'h0000_0000, ST_OK,    6'd0},
      '{ACT_POP_FRONT,  32'h0000_0000, 5'd0,  6'd1,  1'b1, 32'h0000_0000, ST_EMPTY, 6'd0},
      '{ACT_PUSH_FRONT, 32'h5A5A_5A5A, 5'd0,  6'd1,  1'b1, 32'h5A5A_5A5A, ST_OK,    6'd1},
      '{ACT_POP_BACK,   32'h0000_0000, 5'd0,  6'd1,  1'b1, 32'h5A5A_5A5A, ST_OK,    6'd0}
   };

   logic clock = 1'b0;
   logic reset;

   dq_req_if req_ch ();
   dq_rsp_if rsp_ch ();

   double_ended_queue_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // queue predictor state
   logic [DATA_W-1:0] deque_words [DEPTH];
   logic [PTR_W-1:0]  head_idx;
   logic [PTR_W-1:0]  tail_idx;
   int unsigned       held;

   result_type expected_results [$];

   int mismatches;
   int items_accepted;
   int random_items_done;
   int results_seen;
   int ok_seen;
   int empty_seen;
   int full_seen;
   int peak_fill;
   int idle_cycles;
   int burst_left;

   function automatic result_type apply_action(input logic [ACTION_W-1:0] act,
                                               input logic [DATA_W-1:0]   word,
                                               input logic [POS_W-1:0]    pos);
      result_type       res;
      logic [PTR_W-1:0] slot;
      res.data   = '0;
      res.status = ST_OK;
      case (act) inside
         ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if (held >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               if (act == ACT_PUSH_FRONT) begin
                  head_idx              = head_idx - 1'b1;
                  deque_words[head_idx] = word;
               end else begin
                  deque_words[tail_idx] = word;
                  tail_idx              = tail_idx + 1'b1;
               end
               held++;
               res.data = word;
            end
         end
         ACT_POP_FRONT: begin
            if (held == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.data = deque_words[head_idx];
               head_idx = head_idx + 1'b1;
               held--;
            end
         end
         ACT_POP_BACK: begin
            if (held == 0) begin
               res.status = ST_EMPTY;
            end else begin
               tail_idx = tail_idx - 1'b1;
               res.data = deque_words[tail_idx];
               held--;
            end
         end
         ACT_PEEK: begin
            if (pos >= held) begin
               res.status = ST_EMPTY;
            end else begin
               slot     = head_idx + pos;
               res.data = deque_words[slot];
            end
         end
         default: begin
            res.status = ST_EMPTY;
         end
      endcase
      res.fill = FILL_W'(held);
      return res;
   endfunction

   // offers one item, waits for the handshake, records its result, then maybe idles
   task automatic offer_item(input logic [ACTION_W-1:0] act,
                             input logic [DATA_W-1:0]   word,
                             input logic [POS_W-1:0]    pos,
                             input logic                use_typed,
                             input result_type          typed_result);
      result_type predicted;
      int         gap;
      req_ch.valid         <= 1'b1;
      req_ch.action        <= act;
      req_ch.push_data     <= word;
      req_ch.peek_position <= pos;
      do @(posedge clock); while (!req_ch.ready);
      predicted = apply_action(act, word, pos);
      expected_results.push_back(use_typed ? typed_result : predicted);
      items_accepted++;
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
         if (gap > 0) begin
            req_ch.valid         <= 1'b0;
            req_ch.action        <= ACTION_W'($urandom);
            req_ch.push_data     <= $urandom;
            req_ch.peek_position <= POS_W'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   initial begin : stimulus
      int               k;
      int               trend;
      int               roll;
      int               push_pct;
      logic [ACTION_W-1:0] act;
      logic [DATA_W-1:0]   word;
      logic [POS_W-1:0]    pos;
      result_type          typed_result;

      head_idx   = '0;
      tail_idx   = '0;
      held       = 0;
      burst_left = $urandom_range(1, 12);
      trend      = 0;

      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.action        <= ACT_PEEK;
      req_ch.push_data     <= '0;
      req_ch.peek_position <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[r]) begin
         typed_result = '{data: DIRECTED_ROWS[r].exp_data, status: DIRECTED_ROWS[r].exp_status,
                          fill: DIRECTED_ROWS[r].exp_fill};
         for (k = 0; k < DIRECTED_ROWS[r].reps; k++)
            offer_item(DIRECTED_ROWS[r].act, DIRECTED_ROWS[r].word + DATA_W'(k),
                       DIRECTED_ROWS[r].pos, DIRECTED_ROWS[r].typed, typed_result);
      end

      // segments lean towards filling, draining or neither so both ends get hit
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % SEGMENT_ITEMS == 0)
            trend = $urandom_range(0, 2);
         push_pct = (trend == 0) ? 75 : (trend == 1) ? 45 : 60;
         roll     = $urandom_range(0, 99);
         word     = ($urandom_range(0, 9) == 0) ? {DATA_W{roll[0]}} : DATA_W'($urandom);
         pos      = POS_W'($urandom);
         if (roll < 3) begin
            case ($urandom_range(0, 2))
               0:       act = ACT_RSVD_5;
               1:       act = ACT_RSVD_6;
               default: act = ACT_RSVD_7;
            endcase
         end else if (roll < 20) begin
            act = ACT_PEEK;
            if (held > 0 && $urandom_range(0, 4) != 0)
               pos = POS_W'($urandom_range(0, held - 1));
         end else if (roll < push_pct) begin
            act = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
         end else begin
            act = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
         end
         offer_item(act, word, pos, 1'b0, '0);
         random_items_done++;
      end

      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d items (%0d random), %0d results checked, peak fill %0d",
               items_accepted, random_items_done, results_seen, peak_fill);
      $display("status counts: ok %0d, empty or out of range %0d, full %0d",
               ok_seen, empty_seen, full_seen);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // receiver: changing stall patterns plus one long hold-off to back up the block
   initial begin : drive_rsp_ready
      int cyc;
      int mode;
      int period;
      int low_left;
      bit held_off;
      cyc      = 0;
      mode     = 0;
      period   = 2;
      low_left = 0;
      held_off = 1'b0;
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (!held_off && random_items_done >= HOLD_OFF_AFTER) begin
            held_off = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            if (cyc % 48 == 0) begin
               mode   = $urandom_range(0, 3);
               period = $urandom_range(2, 5);
            end
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= 1'($urandom_range(0, 1));
               2: rsp_ch.ready <= (cyc % period != 0);
               default: begin
                  if (low_left > 0) begin
                     rsp_ch.ready <= 1'b0;
                     low_left--;
                  end else begin
                     rsp_ch.ready <= 1'b1;
                     if ($urandom_range(0, 5) == 0)
                        low_left = $urandom_range(2, 6);
                  end
               end
            endcase
            cyc++;
         end
      end
   end

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         case (rsp_ch.status)
            ST_OK:    ok_seen++;
            ST_EMPTY: empty_seen++;
            ST_FULL:  full_seen++;
            default:  ;
         endcase
         if (int'(rsp_ch.fill_count) > peak_fill)
            peak_fill = int'(rsp_ch.fill_count);
         if (expected_results.size() == 0) begin
            $error("result with nothing pending: read_data %h status %0d fill_count %0d",
                   rsp_ch.read_data, rsp_ch.status, rsp_ch.fill_count);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_ch.read_data !== want.data) begin
               $error("read_data: expected %h, actual %h", want.data, rsp_ch.read_data);
               mismatches++;
            end
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
               mismatches++;
            end
            if (rsp_ch.fill_count !== want.fill) begin
               $error("fill_count: expected %0d, actual %0d", want.fill, rsp_ch.fill_count);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      wait (idle_cycles >= STALL_LIMIT);
      $display("no handshake for %0d cycles, %0d results still pending",
               STALL_LIMIT, expected_results.size());
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== double_ended_queue_core.f =====
+incdir+hw/rtl
hw/rtl/dq_pkg.sv
hw/rtl/dq_if.sv
hw/rtl/dq_ram.sv
hw/rtl/dq_ctrl.sv
hw/rtl/dq_rsp_buf.sv
hw/rtl/double_ended_queue_core.sv
tb/tb_top.sv
